// ===== hdl/lpht_pkg.sv =====
// Shared types, codes and defaults for the linear probing hash table.
package lpht_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int SLOT_IDX_W = 4;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic [KEY_W-1:0]        lookup_key;
    logic signed [VAL_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_IDX_W-1:0]   slot_index;
    logic signed [VAL_W-1:0] found_value;
  } rsp_t;

  // One slot as held in the memory.
  typedef struct packed {
    logic                    used;
    logic                    deleted;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

endpackage

// ===== hdl/lpht_mod.sv =====
// Key modulo SLOTS by reciprocal multiplication: low quotient bits first, remainder next cycle.
module lpht_mod #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  output logic                     done,
  output logic [AW-1:0]            rem
);
  import lpht_pkg::*;

  localparam int             SH       = $clog2(SLOTS);
  localparam int             PW       = 2 * KEY_W + 1;
  // floor(2^(KEY_W+SH) / SLOTS) + 1 gives an exact quotient for every key
  localparam logic [KEY_W:0] RECIP    =
    (KEY_W+1)'(((64'd1 << (KEY_W + SH)) / 64'(SLOTS)) + 64'd1);
  localparam logic [AW-1:0]  SLOTS_LO = AW'(SLOTS);

  logic          busy;
  logic [PW-1:0] prod;
  logic [AW-1:0] quot_lo;
  logic [AW-1:0] key_lo;

  // remainder is below SLOTS, so only the low AW bits of key and quotient matter
  assign prod = PW'(key) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
      if (start) begin
        quot_lo <= prod[KEY_W+SH +: AW];
        key_lo  <= key[AW-1:0];
      end
      if (busy) begin
        rem <= key_lo - AW'(quot_lo * SLOTS_LO);
      end
    end
  end

endmodule

// ===== hdl/lpht_ram.sv =====
// Slot store: one write port, one read port, registered read data.
module lpht_ram #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  lpht_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output lpht_pkg::entry_t rdata
);
  import lpht_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/linear_probe_hash_table_top.sv =====
// Top level of the linear probing hash table: control sequencer, hash unit and slot store.
// Sequence: the hash unit reduces the key modulo SLOTS and the home slot is loaded, the store
// reads are registered, one probe per cycle (1 to SLOTS probes), then the output register.
// One transaction at a time, taken only in idle; the probe walk on the single read port sets
// its length, and unused func codes skip it. A stalled response holds the next one.
// Reset: synchronous; then a clearing pass empties every slot in turn, req_stall high.
module linear_probe_hash_table_top #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lpht_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lpht_pkg::rsp_t rsp
);
  import lpht_pkg::*;

  localparam int          AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW:0] SLOTS_W  = (AW+1)'(SLOTS);
  localparam logic [AW-1:0] LAST_A = AW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_DONE
  } state_t;

  state_t        state;
  req_t          req_q;        // transaction being worked on
  rsp_t          res;          // finished result awaiting the output register
  logic [AW-1:0] clr_addr;     // clearing pass pointer
  logic [AW-1:0] issue_addr;   // slot being read this cycle
  logic [AW-1:0] eval_addr;    // slot whose data is on rd_data
  logic          data_ok;      // rd_data belongs to the current probe
  logic [AW:0]   probes;       // probes already judged for this transaction

  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] mod_rem;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        rd_data;

  logic          req_acc;
  logic          is_free;
  logic          is_live_hit;
  logic          is_last;
  logic          stop;
  logic [AW-1:0] next_addr;
  rsp_t          res_next;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign mod_start = req_acc && (req.func inside {FUNC_INSERT, FUNC_SEARCH, FUNC_REMOVE});

  // linear probing wraps round at the last slot
  assign next_addr = (issue_addr == LAST_A) ? '0 : issue_addr + 1'b1;

  lpht_mod #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .key   (req.lookup_key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  lpht_ram #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_addr),
    .rdata (rd_data)
  );

  // Judge the slot that has just come back from the store.
  always_comb begin
    is_free     = !rd_data.used || rd_data.deleted;
    is_live_hit = rd_data.used && !rd_data.deleted && (rd_data.key == req_q.lookup_key);
    is_last     = (probes == SLOTS_W - 1'b1);
    stop        = 1'b0;
    res_next    = '{status: ST_MISS, slot_index: '0, found_value: '0};
    ram_we      = 1'b0;
    ram_waddr   = eval_addr;
    ram_wdata   = rd_data;

    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_PROBE && data_ok) begin
      if (req_q.func == FUNC_INSERT) begin
        if (is_free) begin
          stop      = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = '{used: 1'b1, deleted: 1'b0, key: req_q.lookup_key,
                        value: req_q.entry_value};
          res_next  = '{status: ST_OK, slot_index: SLOT_IDX_W'(eval_addr), found_value: '0};
        end else if (is_last) begin
          stop     = 1'b1;
          res_next = '{status: ST_FULL, slot_index: '0, found_value: '0};
        end
      end else begin
        if (!rd_data.used) begin
          stop = 1'b1;             // never-used slot ends the chain
        end else if (is_live_hit) begin
          stop     = 1'b1;
          res_next = '{status: ST_OK, slot_index: SLOT_IDX_W'(eval_addr), found_value: '0};
          if (req_q.func == FUNC_SEARCH) begin
            res_next.found_value = rd_data.value;
          end else begin
            ram_we            = 1'b1;   // leave a tombstone
            ram_wdata.deleted = 1'b1;
          end
        end else if (is_last) begin
          stop = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      data_ok   <= 1'b0;
      probes    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_A) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            req_q <= req;
            if (mod_start) begin
              state <= S_MOD;
            end else begin
              res   <= '{status: ST_MISS, slot_index: '0, found_value: '0};
              state <= S_DONE;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            issue_addr <= mod_rem;
            data_ok    <= 1'b0;
            probes     <= '0;
            state      <= S_PROBE;
          end
        end
        S_PROBE: begin
          // a read goes out every cycle; data of the previous read is judged alongside
          issue_addr <= next_addr;
          eval_addr  <= issue_addr;
          data_ok    <= !(data_ok && stop);
          if (data_ok) begin
            probes <= probes + 1'b1;
            if (stop) begin
              res   <= res_next;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The probe walk never judges more than SLOTS slots.
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> probes < SLOTS_W)
    else $error("probe count past SLOTS");

  // The store is written only by the clearing pass or at the end of a probe walk.
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || (state == S_PROBE && data_ok && stop)))
    else $error("slot store written outside clear or probe end");

  // The hash unit reports only while the sequencer waits for it.
  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MOD)
    else $error("hash result with no transaction waiting");

  // A failed transaction carries neither slot nor value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.slot_index == '0 && rsp.found_value == '0)
    else $error("nonzero slot or value on failed transaction");

  // A finished walk always moves on to S_DONE next cycle; delivery there may wait on rsp_stall.
  a_stop_done: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE && data_ok && stop |=> state == S_DONE)
    else $error("probe walk ended without a result");
`endif

endmodule
